// File: design/decimal_si_suffix_formatter_defines.svh
// Assertion macros shared by the decimal SI suffix formatter modules.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef DECIMAL_SI_SUFFIX_FORMATTER_DEFINES_SVH
`define DECIMAL_SI_SUFFIX_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dsf_pkg.sv
// Types, constants and helper functions of the decimal SI suffix formatter.
// Used by every module of the block; depends on nothing.
package dsf_pkg;

  localparam int unsigned ValueW    = 24;
  localparam int unsigned NumDigits = 7;
  localparam int unsigned MaxChars  = 5;
  localparam int unsigned CharW     = 7;

  typedef logic [ValueW-1:0]                value_t;
  typedef logic [3:0]                       digit_t;
  typedef digit_t [NumDigits-1:0]           digits_t;
  typedef logic [CharW-1:0]                 char_t;
  typedef logic [$clog2(MaxChars+1)-1:0]    cnt_t;
  typedef logic [$clog2(MaxChars)-1:0]      idx_t;

  localparam value_t ValueMax = value_t'(9999999);

  // Digit positions: weight 10 to the power of the position.
  localparam int unsigned PosMega  = 6;
  localparam int unsigned PosHkilo = 5;
  localparam int unsigned PosTkilo = 4;
  localparam int unsigned PosKilo  = 3;
  localparam int unsigned PosHund  = 2;
  localparam int unsigned PosTens  = 1;
  localparam int unsigned PosUnits = 0;

  localparam char_t CharZero = char_t'(7'h30);
  localparam char_t CharDot  = char_t'(7'h2E);
  localparam char_t CharKilo = char_t'(7'h6B);
  localparam char_t CharMega = char_t'(7'h4D);

  // Text of one value, character 0 first.
  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    cnt_t                 cnt;
  } text_t;

  // Power of ten, evaluated at elaboration.
  function automatic value_t pow10(input int unsigned n);
    value_t p;
    p = value_t'(1);
    for (int unsigned i = 0; i < n; i++) begin
      p = value_t'(p * 10);
    end
    return p;
  endfunction

  // ASCII code of one decimal digit.
  function automatic char_t digit_char(input digit_t d);
    return char_t'(CharZero + char_t'(d));
  endfunction

endpackage

// File: design/dsf_saturate.sv
// Input register of the formatter: takes an item and clamps it to the range.
// Depends on dsf_pkg.
module dsf_saturate
  import dsf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  value_t value_i,
  output logic   valid_o,
  input  logic   ready_i,
  output value_t rem_o
);

  logic   valid_q;
  value_t rem_q, rem_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rem_o   = rem_q;

  // Values beyond the largest printable one are clamped.
  always_comb begin
    rem_d = (value_i > ValueMax) ? ValueMax : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
    end
  end

endmodule

// File: design/dsf_digit_stage.sv
// One pipeline stage that peels one decimal digit off the remainder.
// Depends on dsf_pkg; POS selects the weight of the digit.
module dsf_digit_stage
  import dsf_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  value_t  rem_i,
  input  digits_t digits_i,
  output logic    valid_o,
  input  logic    ready_i,
  output value_t  rem_o,
  output digits_t digits_o
);

  localparam value_t Weight = pow10(POS);

  logic    valid_q;
  value_t  rem_q, rem_d;
  digits_t digits_q, digits_d;
  digit_t  digit;
  value_t  sub;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign rem_o    = rem_q;
  assign digits_o = digits_q;

  // Compare against all nine multiples in parallel; the highest one passed wins.
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int unsigned m = 1; m <= 9; m++) begin
      if (rem_i >= value_t'(value_t'(m) * Weight)) begin
        digit = digit_t'(m);
        sub   = value_t'(value_t'(m) * Weight);
      end
    end
    rem_d         = rem_i - sub;
    digits_d      = digits_i;
    digits_d[POS] = digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q    <= rem_d;
      digits_q <= digits_d;
    end
  end

endmodule

// File: design/dsf_char_format.sv
// Builds the short text of one value from its seven decimal digits.
// Depends on dsf_pkg.
module dsf_char_format
  import dsf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  digits_t digits_i,
  output logic    valid_o,
  input  logic    ready_i,
  output text_t   text_o
);

  logic   valid_q;
  text_t  text_q, text_d;
  digit_t d6, d5, d4, d3, d2, d1, d0;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign text_o  = text_q;

  assign d6 = digits_i[PosMega];
  assign d5 = digits_i[PosHkilo];
  assign d4 = digits_i[PosTkilo];
  assign d3 = digits_i[PosKilo];
  assign d2 = digits_i[PosHund];
  assign d1 = digits_i[PosTens];
  assign d0 = digits_i[PosUnits];

  // The leading nonzero digit picks the form of the text.
  always_comb begin
    text_d.chars = '0;
    text_d.cnt   = cnt_t'(1);
    if (d6 != '0) begin
      text_d.chars[0] = digit_char(d6);
      if (d5 != '0) begin
        text_d.chars[1] = CharDot;
        text_d.chars[2] = digit_char(d5);
        text_d.chars[3] = CharMega;
        text_d.cnt      = cnt_t'(4);
      end else begin
        text_d.chars[1] = CharMega;
        text_d.cnt      = cnt_t'(2);
      end
    end else if (d5 != '0) begin
      text_d.chars[0] = digit_char(d5);
      text_d.chars[1] = digit_char(d4);
      text_d.chars[2] = digit_char(d3);
      text_d.chars[3] = CharKilo;
      text_d.cnt      = cnt_t'(4);
    end else if (d4 != '0) begin
      text_d.chars[0] = digit_char(d4);
      text_d.chars[1] = digit_char(d3);
      if (d2 != '0) begin
        text_d.chars[2] = CharDot;
        text_d.chars[3] = digit_char(d2);
        text_d.chars[4] = CharKilo;
        text_d.cnt      = cnt_t'(5);
      end else begin
        text_d.chars[2] = CharKilo;
        text_d.cnt      = cnt_t'(3);
      end
    end else if (d3 != '0) begin
      text_d.chars[0] = digit_char(d3);
      if (d2 != '0) begin
        text_d.chars[1] = CharDot;
        text_d.chars[2] = digit_char(d2);
        text_d.chars[3] = CharKilo;
        text_d.cnt      = cnt_t'(4);
      end else begin
        text_d.chars[1] = CharKilo;
        text_d.cnt      = cnt_t'(2);
      end
    end else if (d2 != '0) begin
      text_d.chars[0] = digit_char(d2);
      text_d.chars[1] = digit_char(d1);
      text_d.chars[2] = digit_char(d0);
      text_d.cnt      = cnt_t'(3);
    end else if (d1 != '0) begin
      text_d.chars[0] = digit_char(d1);
      text_d.chars[1] = digit_char(d0);
      text_d.cnt      = cnt_t'(2);
    end else begin
      text_d.chars[0] = digit_char(d0);
      text_d.cnt      = cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      text_q <= text_d;
    end
  end

endmodule

// File: design/dsf_char_serializer.sv
// Output stage: holds one value's text and sends it one character per item.
// Depends on dsf_pkg and the assertion macro header.
`include "decimal_si_suffix_formatter_defines.svh"

module dsf_char_serializer
  import dsf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  text_t text_i,
  output logic  valid_o,
  input  logic  ready_i,
  output char_t char_o,
  output logic  last_o
);

  logic  busy_q, busy_d;
  text_t text_q;
  idx_t  idx_q, idx_d;
  logic  is_last;
  logic  load;

  // The last character of the held text frees the buffer for the next one.
  assign is_last = (cnt_t'(idx_q) == cnt_t'(text_q.cnt - cnt_t'(1)));
  assign ready_o = !busy_q || (ready_i && is_last);
  assign load    = valid_i && ready_o;

  assign valid_o = busy_q;
  assign char_o  = text_q.chars[idx_q];
  assign last_o  = is_last;

  // Character index and occupancy.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && ready_i) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      text_q <= text_i;
    end
  end

  `DSF_ASSERT_IMPL(a_idx_in_text, busy_q, cnt_t'(idx_q) < text_q.cnt, "index past end of text")
  `DSF_ASSERT_IMPL(a_cnt_range, busy_q, (text_q.cnt != '0) && (text_q.cnt <= cnt_t'(MaxChars)),
                   "held text has an impossible length")
  `DSF_ASSERT_NEXT(a_drain, busy_q && ready_i && is_last && !valid_i, !busy_q,
                   "buffer still busy after its last character")

endmodule

// File: design/decimal_si_suffix_formatter.sv
// Top level of the decimal SI suffix formatter: input clamp, seven digit
// stages, text builder and character output. Depends on dsf_pkg and the macro header.
//
// Each input item is a 24-bit unsigned value; the block sends its short decimal
// text ("9.9M", "123k", "12.3k", "4k", "875", "0") as 1 to 5 output items, one
// ASCII character each, with tlast on the final character. Digits are truncated,
// values above 9999999 are clamped. The datapath is a nine-stage pipeline
// (clamp, one stage per decimal digit from millions down to units, text build)
// followed by the character output register. A new item may enter every cycle
// while the pipeline has room; sustained throughput is set by the output, which
// sends one character per cycle while m_axis_tready is high, and takes the next
// value's text as the last character of the previous one is accepted.
`include "decimal_si_suffix_formatter_defines.svh"

module decimal_si_suffix_formatter
  import dsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream; tdata: [23:0] value.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // Output stream; tdata: [6:0] char_code, [7] zero fill. tlast: last_char.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  logic    valid [NumDigits+1];
  logic    ready [NumDigits+1];
  value_t  rem   [NumDigits+1];
  digits_t digs  [NumDigits+1];

  logic    fmt_valid;
  logic    fmt_ready;
  text_t   fmt_text;
  char_t   char_code;

  // Input register with clamping.
  dsf_saturate u_saturate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (value_t'(s_axis_tdata)),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .rem_o   (rem[0])
  );

  assign digs[0] = '0;

  // Digit stages, most significant digit first.
  for (genvar k = 0; k < NumDigits; k++) begin : g_digit
    dsf_digit_stage #(
      .POS (NumDigits - 1 - k)
    ) u_digit (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid[k]),
      .ready_o  (ready[k]),
      .rem_i    (rem[k]),
      .digits_i (digs[k]),
      .valid_o  (valid[k+1]),
      .ready_i  (ready[k+1]),
      .rem_o    (rem[k+1]),
      .digits_o (digs[k+1])
    );
  end

  // Text builder.
  dsf_char_format u_format (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid[NumDigits]),
    .ready_o  (ready[NumDigits]),
    .digits_i (digs[NumDigits]),
    .valid_o  (fmt_valid),
    .ready_i  (fmt_ready),
    .text_o   (fmt_text)
  );

  // Character output.
  dsf_char_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fmt_valid),
    .ready_o (fmt_ready),
    .text_i  (fmt_text),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .char_o  (char_code),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, char_code};

  `DSF_ASSERT_IMPL(a_rem_zero, valid[NumDigits], rem[NumDigits] == '0,
                   "remainder left after the units digit")
  `DSF_ASSERT_IMPL(a_mega_digit, valid[NumDigits], digs[NumDigits][PosMega] <= digit_t'(9),
                   "millions digit out of range")
  `DSF_ASSERT_IMPL(a_units_digit, valid[NumDigits], digs[NumDigits][PosUnits] <= digit_t'(9),
                   "units digit out of range")

endmodule
